FILE: hw/rtl/sha_pkg.sv
// sha_pkg: shared types, round constants and helper functions for the hasher
// no dependencies
`default_nettype none
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_final;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} core_state_t;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	localparam logic [255:0] InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [6:0] LenPos = 7'd56;
	localparam logic [6:0] BlockBytes = 7'd64;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] v, input int amt);
		return (v >> amt) | (v << (32 - amt));
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/sha_queue.sv
// sha_queue: small fifo of input beats between the front and the compression core
// depends on sha_pkg
`default_nettype none
module sha_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire sha_pkg::in_beat_t wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output sha_pkg::in_beat_t      rd_data
);
	import sha_pkg::*;

	in_beat_t             mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wptr_q;
	logic [QueuePtrW-1:0] rptr_q;
	logic [QueuePtrW:0]   count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (count_q != QueueDepth[QueuePtrW:0]);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sha_core.sv
// sha_core: byte buffer, padding sequencer, one-round-per-cycle compression, digest output
// depends on sha_pkg
`default_nettype none
module sha_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sha_pkg::in_beat_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sha_pkg::out_beat_t     out_data
);
	import sha_pkg::*;

	core_state_t  state_q;
	core_state_t  state_d;
	logic [31:0]  wbuf_q [16];
	logic [5:0]   fill_q;
	logic [63:0]  bitlen_q;
	logic [255:0] chain_q;
	logic [31:0]  va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	logic [5:0]   round_q;
	logic         final_q;
	logic         last_blk_q;
	logic [2:0]   emit_q;

	logic         take;
	logic         blk_full;
	logic [31:0]  wj;
	logic [31:0]  w15, w2, sg0, sg1, ep0, ep1, ch, mj, t1, t2;
	logic [31:0]  byte_word;
	logic [3:0]   widx;
	logic         need_two;

	assign take = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign blk_full = in_data.has_byte && (fill_q == 6'(BlockBytes - 7'd1));
	assign widx = round_q[3:0];
	assign need_two = (fill_q >= LenPos[5:0]);

	always_comb begin
		w15 = wbuf_q[4'(round_q + 6'd1)];
		w2  = wbuf_q[4'(round_q + 6'd14)];
		sg0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
		sg1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
		if (round_q < 6'd16) begin
			wj = wbuf_q[widx];
		end else begin
			wj = wbuf_q[widx] + sg0 + wbuf_q[4'(round_q + 6'd9)] + sg1;
		end
		ep1 = ror32(ve_q, 6) ^ ror32(ve_q, 11) ^ ror32(ve_q, 25);
		ch  = (ve_q & vf_q) ^ (~ve_q & vg_q);
		t1  = vh_q + ep1 + ch + round_k(round_q) + wj;
		ep0 = ror32(va_q, 2) ^ ror32(va_q, 13) ^ ror32(va_q, 22);
		mj  = (va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q);
		t2  = ep0 + mj;
	end

	always_comb begin
		byte_word = wbuf_q[fill_q[5:2]];
		case (fill_q[1:0])
			2'd0: byte_word[31:24] = in_data.data_byte;
			2'd1: byte_word[23:16] = in_data.data_byte;
			2'd2: byte_word[15:8]  = in_data.data_byte;
			default: byte_word[7:0] = in_data.data_byte;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && (blk_full || in_data.is_final)) begin
					state_d = blk_full ? ST_ROUND : ST_PAD;
				end
			end
			ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (last_blk_q) begin
					state_d = ST_EMIT;
				end else if (final_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: state_d = ST_ROUND;
			ST_EMIT: begin
				if (out_ready && emit_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (state_q == ST_EMIT);
		out_data.digest_word = chain_q[255 - 32*emit_q -: 32];
		out_data.last_word   = (emit_q == 3'd7);
	end

	// word buffer: byte writes, padding, schedule updates
	always_ff @(posedge clk) begin
		if (take && in_data.has_byte) begin
			wbuf_q[fill_q[5:2]] <= byte_word;
		end else if (state_q == ST_PAD) begin
			for (int i = 0; i < 16; i++) begin
				if (i == 14 && !need_two) begin
					wbuf_q[i] <= bitlen_q[63:32];
				end else if (i == 15 && !need_two) begin
					wbuf_q[i] <= bitlen_q[31:0];
				end else if (4'(i) > fill_q[5:2] || last_blk_q) begin
					wbuf_q[i] <= '0;
				end else if (4'(i) == fill_q[5:2]) begin
					case (fill_q[1:0])
						2'd0: wbuf_q[i] <= {PadByte, 24'h0};
						2'd1: wbuf_q[i] <= {wbuf_q[i][31:24], PadByte, 16'h0};
						2'd2: wbuf_q[i] <= {wbuf_q[i][31:16], PadByte, 8'h0};
						default: wbuf_q[i] <= {wbuf_q[i][31:8], PadByte};
					endcase
				end
			end
			if (last_blk_q) begin
				wbuf_q[14] <= bitlen_q[63:32];
				wbuf_q[15] <= bitlen_q[31:0];
				if (fill_q == 6'd0) begin
					wbuf_q[0] <= {PadByte, 24'h0};
				end
			end
		end else if (state_q == ST_ROUND && round_q >= 6'd16) begin
			wbuf_q[widx] <= wj;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			vh_q <= vg_q; vg_q <= vf_q; vf_q <= ve_q; ve_q <= vd_q + t1;
			vd_q <= vc_q; vc_q <= vb_q; vb_q <= va_q; va_q <= t1 + t2;
		end else begin
			{va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q} <= chain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bitlen_q   <= '0;
			chain_q    <= InitHash;
			round_q    <= '0;
			final_q    <= 1'b0;
			last_blk_q <= 1'b0;
			emit_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					if (take) begin
						if (in_data.has_byte) begin
							fill_q   <= fill_q + 6'd1;
							bitlen_q <= bitlen_q + 64'd8;
						end
						final_q    <= in_data.is_final;
						last_blk_q <= 1'b0;
					end
				end
				ST_PAD: begin
					// fill_q = bytes in buffer, or in a follow-on pad block 0 (pad byte still due) or 1 (pad byte placed)
					if (!last_blk_q) begin
						last_blk_q <= !need_two;
					end
				end
				ST_ROUND: round_q <= round_q + 6'd1;
				ST_ADD: begin
					chain_q <= {chain_q[255:224] + va_q, chain_q[223:192] + vb_q,
						chain_q[191:160] + vc_q, chain_q[159:128] + vd_q,
						chain_q[127:96] + ve_q, chain_q[95:64] + vf_q,
						chain_q[63:32] + vg_q, chain_q[31:0] + vh_q};
					round_q <= '0;
					if (final_q && !last_blk_q) begin
						// pad byte already placed when fill was not zero
						last_blk_q <= 1'b1;
						fill_q <= (fill_q == 6'd0) ? 6'd0 : 6'd1;
					end else begin
						fill_q <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							chain_q  <= InitHash;
							bitlen_q <= '0;
							final_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sha256_message_hasher.sv
// Streaming SHA-256 hasher: at most one message byte per input beat, eight digest words out
// after the final beat. The beat that fills a 64-byte block is followed by a busy period in
// the single round unit (64 rounds, one per cycle, plus the chain add). A final beat then
// adds one or two padding blocks (each a padding step, 64 rounds and the chain add), then
// eight output beats. Other beats are taken one per cycle while the core is idle. A four-entry
// input queue lets the sender run ahead during compression.
// depends on sha_pkg, sha_queue, sha_core
`default_nettype none
module sha256_message_hasher (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sha_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sha_pkg::out_beat_t      out_data
);
	import sha_pkg::*;

	logic     q_valid;
	logic     q_ready;
	in_beat_t q_data;

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

FILE: tb/sv/tb_sha256_message_hasher.sv
// tb_sha256_message_hasher: drives byte-serial messages into the SHA-256 hasher and checks each
// digest word against an in-bench predictor of the hash; known digests are typed in for a few rows
// depends on sha_pkg and sha256_message_hasher
`default_nettype none
module tb_sha256_message_hasher;
	import sha_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int RandomBeats = 400;
	localparam int QuietFrom = 340;

	localparam logic [255:0] EmptyDigest =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] AbcDigest =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
	localparam logic [255:0] StartChain = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		in_beat_t beat;
		bit known;
		logic [255:0] digest;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	logic [7:0] msg_block [64];
	int unsigned msg_fill;
	logic [63:0] msg_bits;
	logic [31:0] chain [8];

	out_beat_t digest_q [$];
	int errors;
	int cycles;
	bit quiet;
	int ready_hold;

	sha256_message_hasher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, wj, t1, t2, x, y;
		for (int j = 0; j < 16; j++)
			w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int j = 0; j < 64; j++) begin
			if (j < 16) begin
				wj = w[j];
			end else begin
				x = w[(j - 15) & 15];
				y = w[(j - 2) & 15];
				wj = w[j & 15] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[(j - 7) & 15]
					+ (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
				w[j & 15] = wj;
			end
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundConst[j] + wj;
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic hash_reset();
		for (int i = 0; i < 8; i++)
			chain[i] = StartChain[255 - 32*i -: 32];
		msg_fill = 0;
		msg_bits = '0;
	endtask

	// advances the hash by one beat; done is set with the digest on a final beat
	task automatic hash_beat(input in_beat_t b, output bit done, output logic [255:0] dig);
		done = 1'b0;
		dig = '0;
		if (b.has_byte) begin
			msg_block[msg_fill] = b.data_byte;
			msg_bits += 64'd8;
			msg_fill++;
			if (msg_fill == 64) begin
				compress();
				msg_fill = 0;
			end
		end
		if (b.is_final) begin
			msg_block[msg_fill] = 8'h80;
			msg_fill++;
			if (msg_fill > 56) begin
				while (msg_fill < 64)
					msg_block[msg_fill++] = 8'h00;
				compress();
				msg_fill = 0;
			end
			while (msg_fill < 56)
				msg_block[msg_fill++] = 8'h00;
			for (int i = 0; i < 8; i++)
				msg_block[56 + i] = msg_bits[63 - 8*i -: 8];
			compress();
			dig = {chain[0], chain[1], chain[2], chain[3],
				chain[4], chain[5], chain[6], chain[7]};
			done = 1'b1;
			hash_reset();
		end
	endtask

	task automatic send_beat(input in_beat_t b, input bit known, input logic [255:0] typed);
		bit done;
		logic [255:0] dig;
		out_beat_t w;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		hash_beat(b, done, dig);
		if (done) begin
			if (known)
				dig = typed;
			for (int i = 0; i < 8; i++) begin
				w.digest_word = dig[255 - 32*i -: 32];
				w.last_word = (i == 7);
				digest_q.insert(digest_q.size(), w);
			end
		end
	endtask

	function automatic in_beat_t mk(input logic [7:0] d, input logic hb, input logic fin);
		in_beat_t b;
		b.data_byte = d;
		b.has_byte = hb;
		b.is_final = fin;
		return b;
	endfunction

	// receiver stalls in bursts, except in the quiet phase where it is always ready
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			ready_hold <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest beat %h last %b", $time,
					out_data.digest_word, out_data.last_word);
				errors++;
			end else begin
				if (out_data.digest_word !== digest_q[0].digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time,
						digest_q[0].digest_word, out_data.digest_word);
					errors++;
				end
				if (out_data.last_word !== digest_q[0].last_word) begin
					$display("%0t: last_word expected %b actual %b", $time,
						digest_q[0].last_word, out_data.last_word);
					errors++;
				end
				void'(digest_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		int sent;
		int len;
		int pick;
		in_beat_t b;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		ready_hold = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hash_reset();
		// empty message, abc, ignored bytes, byte extremes, byte on final beat
		rows.insert(rows.size(), '{mk(8'h5a, 1'b0, 1'b1), 1'b1, EmptyDigest});
		rows.insert(rows.size(), '{mk(8'h61, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'hff, 1'b0, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h62, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h63, 1'b1, 1'b1), 1'b1, AbcDigest});
		rows.insert(rows.size(), '{mk(8'h61, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h62, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h63, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'hff, 1'b0, 1'b1), 1'b1, AbcDigest});
		rows.insert(rows.size(), '{mk(8'h00, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'hff, 1'b1, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h00, 1'b0, 1'b0), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'hff, 1'b1, 1'b1), 1'b0, '0});
		rows.insert(rows.size(), '{mk(8'h00, 1'b0, 1'b1), 1'b1, EmptyDigest});
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_beat(rows[i].beat, rows[i].known, rows[i].digest);
		sent = 0;
		while (sent < RandomBeats) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 12);
			else if (pick < 8)
				len = $urandom_range(53, 66);
			else if (pick < 9)
				len = $urandom_range(117, 122);
			else
				len = $urandom_range(13, 52);
			for (int i = 0; i < len; i++) begin
				quiet = (sent >= QuietFrom);
				if ($urandom_range(0, 7) == 0)
					send_beat(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0), 1'b0, '0);
				b = mk(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				// fold the last byte into the final beat now and then
				if (i == len - 1 && $urandom_range(0, 1) == 1)
					b.is_final = 1'b1;
				send_beat(b, 1'b0, '0);
				sent++;
			end
			if (!(len > 0 && b.is_final)) begin
				send_beat(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1), 1'b0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_queue.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_message_hasher.sv
tb/sv/tb_sha256_message_hasher.sv
